// File: hdl/rpt_pkg.sv
// Shared types, widths, reset values and lookup functions for the reflow profile thermostat.
// Used by rpt_ctrl, rpt_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps

package rpt_pkg;

   localparam int DEFAULT_MAX_POINTS = 8;

   localparam int OPCODE_W   = 3;
   localparam int TEMP_W     = 12;
   localparam int PIDX_W     = 3;
   localparam int TIME_W     = 16;
   localparam int DEG_W      = 8;
   localparam int TPS_W      = 10;
   localparam int CNT_W      = 4;
   localparam int MARGIN_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int POINT_W = TIME_W + DEG_W;

   // Percent through a stage is 0 to 99, so seven quotient bits suffice.
   localparam int PCT_W     = 7;
   localparam int PCT_SCALE = 100;
   localparam int NUM_W     = TIME_W + PCT_W;
   localparam int MAG_W     = DEG_W + PCT_W;

   // Division by 100 as a multiplication by 2^20 / 100, rounded up.
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_100   = 10486;
   localparam int RECIP_W     = MAG_W + 14;

   localparam logic [TPS_W-1:0]    TPS_RESET    = TPS_W'(125);
   localparam logic [CNT_W-1:0]    COUNT_RESET  = CNT_W'(6);
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(2);
   localparam logic [TEMP_W-1:0]   CLIP_RESET   = TEMP_W'(3999);

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK       = 3'd0,
      OP_SAMPLE     = 3'd1,
      OP_START_STOP = 3'd2,
      OP_MODE       = 3'd3,
      OP_LOAD       = 3'd4
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TPS    = 2'd0,
      CSR_COUNT  = 2'd1,
      CSR_MARGIN = 2'd2,
      CSR_CLIP   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ADDR_LAST,
      ADDR_ZERO,
      ADDR_NEXT
   } addr_sel_type;

   typedef struct packed {
      logic         apply;
      addr_sel_type addr_sel;
      logic         cap_last;
      logic         cap_first;
      logic         scan_step;
      logic         div_init;
      logic         div_step;
      logic         mul;
      logic         recip;
      logic         target;
      logic         control;
      logic         rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic pass;
      logic at_last;
   } dp_status_type;

   // Profile point contents before the point is first loaded.
   function automatic logic [TIME_W-1:0] reset_time(input int idx);
      logic [TIME_W-1:0] value;
      unique case (idx)
         1:       value = TIME_W'(30);
         2:       value = TIME_W'(120);
         3:       value = TIME_W'(150);
         4:       value = TIME_W'(210);
         5:       value = TIME_W'(240);
         default: value = '0;
      endcase
      return value;
   endfunction

   function automatic logic [DEG_W-1:0] reset_deg(input int idx);
      logic [DEG_W-1:0] value;
      unique case (idx)
         0:       value = DEG_W'(25);
         1:       value = DEG_W'(100);
         2:       value = DEG_W'(150);
         3:       value = DEG_W'(183);
         4:       value = DEG_W'(235);
         5:       value = DEG_W'(183);
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// File: hdl/rpt_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Stand-alone; used for the profile point store.
`timescale 1ns / 1ps

module rpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/rpt_ctrl.sv
// Sequencing state machine of the reflow profile thermostat.
// Depends on rpt_pkg for the command and status structs.
`timescale 1ns / 1ps

module rpt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rpt_pkg::dp_status_type status,
   output rpt_pkg::dp_cmd_type    cmd
);
   import rpt_pkg::*;

   localparam int DCNT_W = $clog2(PCT_W);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LAST,
      S_FIRST,
      S_CUR,
      S_CHK,
      S_DIVINIT,
      S_DIV,
      S_MUL,
      S_RECIP,
      S_TGT,
      S_CTRL,
      S_OUT
   } state_type;

   state_type         state_ff;
   logic              ready_ff;
   logic              rsp_valid_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic              accept;
   logic              slot_free;

   assign accept    = req_valid && ready_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      cmd.addr_sel = ADDR_ZERO;
      unique case (state_ff)
         S_IDLE:    cmd.apply = accept;
         S_LAST:    cmd.addr_sel = ADDR_LAST;
         S_FIRST: begin
            cmd.cap_last = 1'b1;
            cmd.addr_sel = ADDR_ZERO;
         end
         S_CUR: begin
            cmd.cap_first = 1'b1;
            cmd.addr_sel  = ADDR_NEXT;
         end
         S_CHK: begin
            cmd.scan_step = 1'b1;
            cmd.addr_sel  = ADDR_NEXT;
         end
         S_DIVINIT: cmd.div_init = 1'b1;
         S_DIV:     cmd.div_step = 1'b1;
         S_MUL:     cmd.mul = 1'b1;
         S_RECIP:   cmd.recip = 1'b1;
         S_TGT:     cmd.target = 1'b1;
         S_CTRL:    cmd.control = 1'b1;
         S_OUT:     cmd.rsp_load = slot_free;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  state_ff <= S_LAST;
               end
            end
            S_LAST:  state_ff <= S_FIRST;
            S_FIRST: state_ff <= S_CUR;
            S_CUR:   state_ff <= S_CHK;
            S_CHK: begin
               if (!status.pass) begin
                  state_ff <= S_DIVINIT;
               end else if (status.at_last) begin
                  state_ff <= S_TGT;
               end
            end
            S_DIVINIT: begin
               div_cnt_ff <= DCNT_W'(PCT_W - 1);
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               if (div_cnt_ff == '0) begin
                  state_ff <= S_MUL;
               end else begin
                  div_cnt_ff <= div_cnt_ff - DCNT_W'(1);
               end
            end
            S_MUL:   state_ff <= S_RECIP;
            S_RECIP: state_ff <= S_TGT;
            S_TGT:   state_ff <= S_CTRL;
            S_CTRL:  state_ff <= S_OUT;
            S_OUT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  ready_ff     <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/rpt_dp.sv
// Datapath of the reflow profile thermostat: settings, oven state, point store,
// stage scan, percent divider, interpolation and relay control. Depends on rpt_pkg, rpt_ram.
`timescale 1ns / 1ps

module rpt_dp #(
   parameter int MAX_POINTS = rpt_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rpt_pkg::dp_cmd_type             cmd,
   output rpt_pkg::dp_status_type          status,
   input  logic                            csr_we,
   input  logic [rpt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [rpt_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [rpt_pkg::TEMP_W-1:0]      req_raw_temp,
   input  logic [rpt_pkg::PIDX_W-1:0]      req_point_index,
   input  logic [rpt_pkg::TIME_W-1:0]      req_point_time,
   input  logic [rpt_pkg::DEG_W-1:0]       req_point_degrees,
   output logic                            rsp_heater,
   output logic                            rsp_following,
   output logic                            rsp_profile_mode,
   output logic [rpt_pkg::DEG_W-1:0]       rsp_setpoint,
   output logic [rpt_pkg::TIME_W-1:0]      rsp_elapsed_seconds,
   output logic [rpt_pkg::TEMP_W-1:0]      rsp_oven_temp
);
   import rpt_pkg::*;

   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int EXT_W   = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam int DEGC_W  = TEMP_W - 2;
   localparam int CMP_W   = DEGC_W + 1;

   // Settings.
   logic [TPS_W-1:0]    tps_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic [TEMP_W-1:0]   clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff    <= TPS_RESET;
         count_ff  <= COUNT_RESET;
         margin_ff <= MARGIN_RESET;
         clip_ff   <= CLIP_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TPS:    tps_ff    <= csr_wdata[TPS_W-1:0];
            CSR_COUNT:  count_ff  <= csr_wdata[CNT_W-1:0];
            CSR_MARGIN: margin_ff <= csr_wdata[MARGIN_W-1:0];
            CSR_CLIP:   clip_ff   <= csr_wdata[TEMP_W-1:0];
            default:    tps_ff    <= tps_ff;
         endcase
      end
   end

   // Points in use, clamped to the range two to MAX_POINTS.
   logic [EXT_W-1:0] cnt_ext;
   logic [EXT_W-1:0] used_ext;
   logic [IDX_W-1:0] last_idx;

   always_comb begin
      cnt_ext = EXT_W'(count_ff);
      if (cnt_ext < EXT_W'(2)) begin
         used_ext = EXT_W'(2);
      end else if (cnt_ext > EXT_W'(MAX_POINTS)) begin
         used_ext = EXT_W'(MAX_POINTS);
      end else begin
         used_ext = cnt_ext;
      end
   end

   assign last_idx = IDX_W'(used_ext - EXT_W'(1));

   // Oven state and event handling.
   logic              heater_ff, heater_in;
   logic              follow_ff, follow_in;
   logic              mode_ff, mode_in;
   logic [TEMP_W-1:0] latest_ff, latest_in;
   logic [TPS_W-1:0]  frac_ff, frac_in;
   logic [TIME_W-1:0] sec_ff, sec_in;
   logic [DEG_W-1:0]  target_ff;
   logic [TIME_W-1:0] last_time_ff;

   logic [TPS_W:0]     frac_inc;
   logic [TPS_W-1:0]   tps_eff;
   logic [DEGC_W-1:0]  deg_now;
   logic               low_hit;
   logic               high_hit;

   assign frac_inc = {1'b0, frac_ff} + (TPS_W + 1)'(1);
   assign tps_eff  = (tps_ff == '0) ? TPS_W'(1) : tps_ff;
   assign deg_now  = latest_ff[TEMP_W-1:2];
   assign low_hit  = (CMP_W'(deg_now) + CMP_W'(margin_ff)) < CMP_W'(target_ff);
   assign high_hit = deg_now > DEGC_W'(target_ff);

   always_comb begin
      heater_in = heater_ff;
      follow_in = follow_ff;
      mode_in   = mode_ff;
      latest_in = latest_ff;
      frac_in   = frac_ff;
      sec_in    = sec_ff;
      if (cmd.apply) begin
         unique case (opcode_type'(req_opcode))
            OP_TICK: begin
               if (frac_inc >= {1'b0, tps_eff}) begin
                  frac_in = '0;
                  if (sec_ff != '1) begin
                     sec_in = sec_ff + TIME_W'(1);
                  end
               end else begin
                  frac_in = frac_inc[TPS_W-1:0];
               end
            end
            OP_SAMPLE: latest_in = (req_raw_temp > clip_ff) ? clip_ff : req_raw_temp;
            OP_START_STOP: begin
               if (!mode_ff) begin
                  heater_in = !heater_ff;
               end else begin
                  follow_in = !follow_ff;
               end
               frac_in = '0;
               sec_in  = '0;
            end
            OP_MODE: mode_in = !mode_ff;
            default: mode_in = mode_ff;
         endcase
      end else if (cmd.control && follow_ff) begin
         if (!heater_ff && low_hit) begin
            heater_in = 1'b1;
         end else if (heater_ff && high_hit) begin
            heater_in = 1'b0;
         end
         if (sec_ff >= last_time_ff) begin
            follow_in = 1'b0;
            heater_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heater_ff <= 1'b0;
         follow_ff <= 1'b0;
         mode_ff   <= 1'b0;
         latest_ff <= '0;
         frac_ff   <= '0;
         sec_ff    <= '0;
      end else begin
         heater_ff <= heater_in;
         follow_ff <= follow_in;
         mode_ff   <= mode_in;
         latest_ff <= latest_in;
         frac_ff   <= frac_in;
         sec_ff    <= sec_in;
      end
   end

   // Point store. An entry that was never loaded reads as its reset value.
   logic [EXT_W-1:0]      widx_ext;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [MAX_POINTS-1:0] pt_valid_ff;
   logic [IDX_W-1:0]      scan_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      rd_addr_ff;
   logic                  rd_valid_ff;
   logic [POINT_W-1:0]    ram_q;
   logic [POINT_W-1:0]    rd_point;
   logic [TIME_W-1:0]     rd_time;
   logic [DEG_W-1:0]      rd_deg;

   assign widx_ext = EXT_W'(req_point_index);
   assign wr_en    = cmd.apply && (req_opcode == OP_LOAD) && (widx_ext < EXT_W'(MAX_POINTS));
   assign wr_addr  = widx_ext[IDX_W-1:0];

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_LAST: rd_addr = last_idx;
         ADDR_ZERO: rd_addr = '0;
         ADDR_NEXT: rd_addr = scan_ff + IDX_W'(1);
         default:   rd_addr = '0;
      endcase
   end

   rpt_ram #(
      .WIDTH(POINT_W),
      .DEPTH(MAX_POINTS)
   ) u_points (
      .clock(clock),
      .we   (wr_en),
      .waddr(wr_addr),
      .wdata({req_point_time, req_point_degrees}),
      .raddr(rd_addr),
      .rdata(ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_valid_ff <= '0;
      end else if (wr_en) begin
         pt_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr;
      rd_valid_ff <= pt_valid_ff[rd_addr];
   end

   assign rd_point = rd_valid_ff ? ram_q
                                 : {reset_time(int'(rd_addr_ff)), reset_deg(int'(rd_addr_ff))};
   assign rd_time  = rd_point[POINT_W-1:DEG_W];
   assign rd_deg   = rd_point[DEG_W-1:0];

   assign status.pass    = sec_ff >= rd_time;
   assign status.at_last = scan_ff == last_idx;

   // Stage scan: cur holds the stage start, nxt the stage end.
   logic [TIME_W-1:0] cur_time_ff;
   logic [DEG_W-1:0]  cur_deg_ff;
   logic [TIME_W-1:0] nxt_time_ff;
   logic [DEG_W-1:0]  nxt_deg_ff;
   logic              last_stage_ff;

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         scan_ff       <= '0;
         last_stage_ff <= 1'b0;
      end
      if (cmd.cap_last) begin
         last_time_ff <= rd_time;
      end
      if (cmd.cap_first) begin
         cur_time_ff <= rd_time;
         cur_deg_ff  <= rd_deg;
         scan_ff     <= scan_ff + IDX_W'(1);
      end
      if (cmd.scan_step) begin
         if (status.pass) begin
            cur_time_ff <= rd_time;
            cur_deg_ff  <= rd_deg;
            if (status.at_last) begin
               last_stage_ff <= 1'b1;
            end else begin
               scan_ff <= scan_ff + IDX_W'(1);
            end
         end else begin
            nxt_time_ff <= rd_time;
            nxt_deg_ff  <= rd_deg;
         end
      end
   end

   // Percent through the stage: restoring division, one quotient bit a cycle.
   logic [NUM_W-1:0]  num_full;
   logic [TIME_W-1:0] rem_ff;
   logic [PCT_W-1:0]  numlo_ff;
   logic [TIME_W-1:0] span_ff;
   logic [PCT_W-1:0]  quo_ff;
   logic              zero_pct_ff;
   logic [TIME_W:0]   trial;
   logic              trial_ge;

   assign num_full = NUM_W'(sec_ff - cur_time_ff) * NUM_W'(PCT_SCALE);
   assign trial    = {rem_ff, numlo_ff[PCT_W-1]};
   assign trial_ge = trial >= {1'b0, span_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff      <= num_full[NUM_W-1:PCT_W];
         numlo_ff    <= num_full[PCT_W-1:0];
         span_ff     <= nxt_time_ff - cur_time_ff;
         quo_ff      <= '0;
         zero_pct_ff <= (sec_ff < cur_time_ff) || (nxt_time_ff <= cur_time_ff);
      end
      if (cmd.div_step) begin
         rem_ff   <= trial_ge ? TIME_W'(trial - {1'b0, span_ff}) : trial[TIME_W-1:0];
         numlo_ff <= {numlo_ff[PCT_W-2:0], 1'b0};
         quo_ff   <= {quo_ff[PCT_W-2:0], trial_ge};
      end
   end

   // Interpolation: |stop - start| * percent, then division by 100 by reciprocal.
   logic [PCT_W-1:0]   pct;
   logic               down;
   logic [DEG_W-1:0]   dmag;
   logic               down_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic [DEG_W-1:0]   step_deg;
   logic [DEG_W-1:0]   target_in;

   assign pct      = zero_pct_ff ? '0 : quo_ff;
   assign down     = nxt_deg_ff < cur_deg_ff;
   assign dmag     = down ? (cur_deg_ff - nxt_deg_ff) : (nxt_deg_ff - cur_deg_ff);
   assign step_deg = recip_ff[RECIP_SHIFT +: DEG_W];

   always_comb begin
      if (last_stage_ff) begin
         target_in = cur_deg_ff;
      end else if (down_ff) begin
         target_in = cur_deg_ff - step_deg;
      end else begin
         target_in = cur_deg_ff + step_deg;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         down_ff <= down;
         mag_ff  <= MAG_W'(dmag) * MAG_W'(pct);
      end
      if (cmd.recip) begin
         recip_ff <= RECIP_W'(mag_ff) * RECIP_W'(RECIP_100);
      end
      if (cmd.target) begin
         target_ff <= target_in;
      end
   end

   // Result word.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_heater          <= heater_ff;
         rsp_following       <= follow_ff;
         rsp_profile_mode    <= mode_ff;
         rsp_setpoint        <= target_ff;
         rsp_elapsed_seconds <= sec_ff;
         rsp_oven_temp       <= latest_ff;
      end
   end

endmodule

// File: hdl/reflow_profile_thermostat.sv
// Top level of the reflow profile thermostat: request, result and settings ports.
// Depends on rpt_pkg, rpt_ctrl and rpt_dp.
// From acceptance to result the stage scan reads one point per cycle from the point store;
// unless the last stage is in force, the percent divider then produces one quotient bit per
// cycle. A result waiting in the output register does not hold off the next request.
// Synchronous reset restores settings, oven state and profile points at once; no clearing
// pass is needed.
`timescale 1ns / 1ps

module reflow_profile_thermostat #(
   parameter int MAX_POINTS = rpt_pkg::DEFAULT_MAX_POINTS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel: one event word per handshake.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rpt_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [rpt_pkg::TEMP_W-1:0]      req_raw_temp,
   input  logic [rpt_pkg::PIDX_W-1:0]      req_point_index,
   input  logic [rpt_pkg::TIME_W-1:0]      req_point_time,
   input  logic [rpt_pkg::DEG_W-1:0]       req_point_degrees,
   // Result channel: one status word for every request word.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_heater,
   output logic                            rsp_following,
   output logic                            rsp_profile_mode,
   output logic [rpt_pkg::DEG_W-1:0]       rsp_setpoint,
   output logic [rpt_pkg::TIME_W-1:0]      rsp_elapsed_seconds,
   output logic [rpt_pkg::TEMP_W-1:0]      rsp_oven_temp,
   // Settings write port.
   input  logic                            csr_we,
   input  logic [rpt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rpt_pkg::*;

   // The controller only sequences; all data arithmetic and the oven state live in the datapath.
   // Each word first updates the oven state, then the controller walks the profile
   // points to find the current stage, runs the percent divider and the interpolation unless the
   // last stage is in force, and finally applies the relay rule before the word is handed out.
   dp_cmd_type    cmd;
   dp_status_type status;

   rpt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds the point store; unloaded points read as the default profile.
   rpt_dp #(
      .MAX_POINTS(MAX_POINTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_opcode         (req_opcode),
      .req_raw_temp       (req_raw_temp),
      .req_point_index    (req_point_index),
      .req_point_time     (req_point_time),
      .req_point_degrees  (req_point_degrees),
      .rsp_heater         (rsp_heater),
      .rsp_following      (rsp_following),
      .rsp_profile_mode   (rsp_profile_mode),
      .rsp_setpoint       (rsp_setpoint),
      .rsp_elapsed_seconds(rsp_elapsed_seconds),
      .rsp_oven_temp      (rsp_oven_temp)
   );

endmodule

// File: hdl/rpt_checker.sv
// Port-level checks for the reflow profile thermostat, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module rpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_heater,
   input logic        rsp_following,
   input logic        rsp_profile_mode,
   input logic [7:0]  rsp_setpoint,
   input logic [15:0] rsp_elapsed_seconds,
   input logic [11:0] rsp_oven_temp
);

   logic [1:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Words accepted whose results have not yet been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(req_take) - 2'(rsp_take);
      end
   end

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result valid or request not ready after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("request taken while a word is still being worked on");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result offered without an outstanding request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two words outstanding");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heater)
         && $stable(rsp_following) && $stable(rsp_profile_mode)
         && $stable(rsp_setpoint) && $stable(rsp_elapsed_seconds)
         && $stable(rsp_oven_temp))
      else $error("stalled result changed or withdrawn");

endmodule

bind reflow_profile_thermostat rpt_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_heater         (rsp_heater),
   .rsp_following      (rsp_following),
   .rsp_profile_mode   (rsp_profile_mode),
   .rsp_setpoint       (rsp_setpoint),
   .rsp_elapsed_seconds(rsp_elapsed_seconds),
   .rsp_oven_temp      (rsp_oven_temp)
);
